### rtl/skvc_pkg.sv
// Shared types and constants of the screen keyed vertex cache.
`default_nettype none

package skvc_pkg;

  localparam int unsigned COORD_BITS_DEF = 8;
  localparam int unsigned SCREEN_W       = 12;

  // Largest Q16.16 difference that still counts as the same position (0.1).
  localparam logic signed [32:0] NEAR_LIMIT = 33'sd6553;

  localparam logic [2:0] MARK_VALID = 3'd1;
  localparam logic [2:0] MARK_AMBIG = 3'd5;

  localparam logic REQ_STORE  = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    STAT_NONE    = 2'd0,
    STAT_WRITTEN = 2'd1,
    STAT_AMBIG   = 2'd2,
    STAT_FAIL    = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    CM_INIT  = 4'b0001,
    CM_WRITE = 4'b0010,
    CM_READ  = 4'b0100,
    CM_FAIL  = 4'b1000
  } mode_t;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } ctl_state_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] flags;
    logic [31:0] word;
    logic [31:0] id;
    logic [2:0]  mark;
  } entry_t;

  typedef struct packed {
    logic        req_type;
    logic        vertex_present;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] vert_flags;
    logic [31:0] vert_word;
    logic [31:0] vert_id;
  } req_t;

endpackage

`default_nettype wire

### rtl/skvc_if.sv
// Request and result channel interfaces of the screen keyed vertex cache.
`default_nettype none

interface skvc_req_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic signed [11:0] sx;
  logic signed [11:0] sy;
  logic               vertex_present;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic [31:0]        vert_flags;
  logic [31:0]        vert_word;
  logic [31:0]        vert_id;

  modport source (
    output valid, req_type, sx, sy, vertex_present, pos_x, pos_y, pos_z,
           vert_flags, vert_word, vert_id,
    input  ready
  );
  modport sink (
    input  valid, req_type, sx, sy, vertex_present, pos_x, pos_y, pos_z,
           vert_flags, vert_word, vert_id,
    output ready
  );
endinterface

interface skvc_rsp_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic [1:0]         store_status;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic [31:0]        out_flags;
  logic [31:0]        out_word;
  logic [31:0]        out_id;

  modport source (
    output valid, hit, store_status, out_x, out_y, out_z, out_flags, out_word, out_id,
    input  ready
  );
  modport sink (
    input  valid, hit, store_status, out_x, out_y, out_z, out_flags, out_word, out_id,
    output ready
  );
endinterface

`default_nettype wire

### rtl/skvc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module skvc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### rtl/screen_keyed_vertex_cache.sv
// Top level of the screen keyed vertex cache.
//
// Each request is handled in two steps: in the cycle it is accepted the entry at (sx, sy)
// is read from the entry RAM, and then, in the EXEC state, the entry is checked, written back
// and the result is loaded into the output register. That single read-modify-write of the
// entry RAM means a new request is accepted only once the last one is through its update; the
// update waits while the output register still holds a result that has not been taken. After
// reset the whole RAM of 2^(2*COORD_BITS) entries (65536 at the default of 8) is cleared, one
// entry per cycle; in_req.ready stays low until that pass is done.
`default_nettype none

module screen_keyed_vertex_cache #(
  parameter int unsigned COORD_BITS = skvc_pkg::COORD_BITS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  skvc_req_if.sink    in_req,
  skvc_rsp_if.source  out_rsp
);

  localparam int unsigned AW    = 2 * COORD_BITS;
  localparam int unsigned DEPTH = 1 << AW;
  localparam int unsigned EW    = $bits(skvc_pkg::entry_t);
  localparam int unsigned SW    = skvc_pkg::SCREEN_W;
  localparam logic [COORD_BITS-1:0] FLIP = {1'b1, {(COORD_BITS-1){1'b0}}};

  function automatic logic coord_ok(input logic [SW-1:0] c);
    return c[SW-1:COORD_BITS-1] == {(SW-COORD_BITS+1){c[SW-1]}};
  endfunction

  // True when two Q16.16 values differ by more than the near limit.
  function automatic logic far_apart(input logic [31:0] a, input logic [31:0] b);
    logic signed [32:0] d;
    d = $signed({a[31], a}) - $signed({b[31], b});
    return (d > skvc_pkg::NEAR_LIMIT) || (d < -skvc_pkg::NEAR_LIMIT);
  endfunction

  skvc_pkg::ctl_state_t fsm_r;
  skvc_pkg::mode_t      mode_r, mode_nxt;
  logic [31:0]          base_r, base_nxt;
  logic [31:0]          last_r, last_nxt;
  logic [AW-1:0]        clr_addr_r;
  skvc_pkg::req_t       req_r;
  logic [AW-1:0]        slot_r;
  logic                 range_ok_r;

  logic                 out_valid_r;
  logic                 out_hit_r, hit_nxt;
  skvc_pkg::status_t    out_status_r, status_nxt;
  skvc_pkg::entry_t     out_ent_r, res_ent;

  logic                 in_acc, out_free, exec_go;
  logic [AW-1:0]        in_slot;
  logic                 in_range;
  logic [EW-1:0]        rd_data;
  skvc_pkg::entry_t     ent, upd_ent;
  logic                 upd_wr;
  logic                 in_sess;
  logic                 ram_wr_en;
  logic [AW-1:0]        ram_wr_addr;
  logic [EW-1:0]        ram_wr_data;

  assign in_req.ready = (fsm_r == skvc_pkg::ST_IDLE);
  assign in_acc       = in_req.valid && in_req.ready;
  assign out_free     = !out_valid_r || out_rsp.ready;
  assign exec_go      = (fsm_r == skvc_pkg::ST_EXEC) && out_free;

  assign in_range = coord_ok(in_req.sx) && coord_ok(in_req.sy);
  assign in_slot  = {in_req.sy[COORD_BITS-1:0] ^ FLIP, in_req.sx[COORD_BITS-1:0] ^ FLIP};

  // Control state and clearing pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r      <= skvc_pkg::ST_CLEAR;
      clr_addr_r <= '0;
      mode_r     <= skvc_pkg::CM_INIT;
      base_r     <= '0;
      last_r     <= '0;
    end else begin
      unique case (fsm_r)
        skvc_pkg::ST_CLEAR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == {AW{1'b1}}) begin
            fsm_r <= skvc_pkg::ST_IDLE;
          end
        end
        skvc_pkg::ST_IDLE: begin
          if (in_acc) begin
            fsm_r <= skvc_pkg::ST_EXEC;
          end
        end
        skvc_pkg::ST_EXEC: begin
          if (exec_go) begin
            fsm_r <= skvc_pkg::ST_IDLE;
          end
        end
        default: fsm_r <= skvc_pkg::ST_CLEAR;
      endcase
      if (exec_go) begin
        mode_r <= mode_nxt;
        base_r <= base_nxt;
        last_r <= last_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r.req_type       <= in_req.req_type;
      req_r.vertex_present <= in_req.vertex_present;
      req_r.pos_x          <= in_req.pos_x;
      req_r.pos_y          <= in_req.pos_y;
      req_r.pos_z          <= in_req.pos_z;
      req_r.vert_flags     <= in_req.vert_flags;
      req_r.vert_word      <= in_req.vert_word;
      req_r.vert_id        <= in_req.vert_id;
      slot_r               <= in_slot;
      range_ok_r           <= in_range;
    end
  end

  assign ent = skvc_pkg::entry_t'(rd_data);

  // A store with a vertex present moves the session registers before its own entry is checked.
  always_comb begin
    mode_nxt   = mode_r;
    base_nxt   = base_r;
    last_nxt   = last_r;
    hit_nxt    = 1'b0;
    status_nxt = skvc_pkg::STAT_NONE;
    res_ent    = '0;
    upd_wr     = 1'b0;
    upd_ent    = ent;

    if (req_r.req_type == skvc_pkg::REQ_STORE && req_r.vertex_present) begin
      if (mode_r != skvc_pkg::CM_WRITE) begin
        base_nxt = req_r.vert_id;
      end
      last_nxt = req_r.vert_id;
    end

    if (last_nxt >= base_nxt) begin
      in_sess = ent.id >= base_nxt;
    end else begin
      in_sess = (ent.id >= base_nxt) || (ent.id <= last_nxt);
    end

    if (req_r.req_type == skvc_pkg::REQ_STORE) begin
      if (!req_r.vertex_present) begin
        mode_nxt   = skvc_pkg::CM_FAIL;
        status_nxt = skvc_pkg::STAT_FAIL;
      end else begin
        mode_nxt = skvc_pkg::CM_WRITE;
        if (range_ok_r) begin
          upd_wr = 1'b1;
          if (in_sess && ent.word == req_r.vert_word &&
              (far_apart(ent.x, req_r.pos_x) || far_apart(ent.y, req_r.pos_y) ||
               far_apart(ent.z, req_r.pos_z))) begin
            upd_ent.mark = skvc_pkg::MARK_AMBIG;
            status_nxt   = skvc_pkg::STAT_AMBIG;
          end else begin
            upd_ent.x     = req_r.pos_x;
            upd_ent.y     = req_r.pos_y;
            upd_ent.z     = req_r.pos_z;
            upd_ent.flags = req_r.vert_flags;
            upd_ent.word  = req_r.vert_word;
            upd_ent.id    = req_r.vert_id;
            upd_ent.mark  = skvc_pkg::MARK_VALID;
            status_nxt    = skvc_pkg::STAT_WRITTEN;
          end
        end
      end
    end else if (mode_r != skvc_pkg::CM_FAIL) begin
      mode_nxt = skvc_pkg::CM_READ;
      if (range_ok_r && in_sess && ent.mark == skvc_pkg::MARK_VALID) begin
        hit_nxt = 1'b1;
        res_ent = ent;
      end
    end
  end

  always_comb begin
    if (fsm_r == skvc_pkg::ST_CLEAR) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = clr_addr_r;
      ram_wr_data = '0;
    end else begin
      ram_wr_en   = exec_go && upd_wr;
      ram_wr_addr = slot_r;
      ram_wr_data = upd_ent;
    end
  end

  skvc_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (in_acc),
    .rd_addr (in_slot),
    .rd_data (rd_data)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec_go) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      out_hit_r    <= hit_nxt;
      out_status_r <= status_nxt;
      out_ent_r    <= res_ent;
    end
  end

  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.hit          = out_hit_r;
  assign out_rsp.store_status = out_status_r;
  assign out_rsp.out_x        = $signed(out_ent_r.x);
  assign out_rsp.out_y        = $signed(out_ent_r.y);
  assign out_rsp.out_z        = $signed(out_ent_r.z);
  assign out_rsp.out_flags    = out_ent_r.flags;
  assign out_rsp.out_word     = out_ent_r.word;
  assign out_rsp.out_id       = out_ent_r.id;

endmodule

`default_nettype wire

### rtl/skvc_checker.sv
// Port-level assertions of the screen keyed vertex cache and their bind.
`default_nettype none

module skvc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_hit,
  input wire logic [1:0]  out_status,
  input wire logic [31:0] out_x,
  input wire logic [31:0] out_y,
  input wire logic [31:0] out_z,
  input wire logic [31:0] out_flags,
  input wire logic [31:0] out_word,
  input wire logic [31:0] out_id
);

  // Reset leaves no result pending and holds off requests for the clearing pass.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("result or ready seen right after reset");

  // Only one request is in flight at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in flight");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_x == 32'd0 && out_y == 32'd0 && out_z == 32'd0 &&
      out_flags == 32'd0 && out_word == 32'd0 && out_id == 32'd0)
    else $error("result without hit carries nonzero entry data");

  a_hit_is_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> out_status == skvc_pkg::STAT_NONE)
    else $error("hit reported together with a store status");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hit) && $stable(out_status) &&
      $stable(out_x) && $stable(out_id))
    else $error("stalled result changed");

endmodule

bind screen_keyed_vertex_cache skvc_checker u_skvc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_req.valid),
  .in_ready   (in_req.ready),
  .out_valid  (out_rsp.valid),
  .out_ready  (out_rsp.ready),
  .out_hit    (out_rsp.hit),
  .out_status (out_rsp.store_status),
  .out_x      (out_rsp.out_x),
  .out_y      (out_rsp.out_y),
  .out_z      (out_rsp.out_z),
  .out_flags  (out_rsp.out_flags),
  .out_word   (out_rsp.out_word),
  .out_id     (out_rsp.out_id)
);

`default_nettype wire

### tb/sv/tb_screen_keyed_vertex_cache.sv
// Self-checking testbench of the screen keyed vertex cache: random and directed requests.
module tb_screen_keyed_vertex_cache;
  timeunit 1ns;
  timeprecision 1ps;

  import skvc_pkg::*;

  localparam int unsigned CB          = COORD_BITS_DEF;
  localparam int unsigned ENTRIES     = 1 << (2 * CB);
  localparam int          HALF        = 1 << (CB - 1);
  localparam int          ITEM_TARGET = 1400;
  localparam int          STALL_LIMIT = 200000;
  localparam int          HOLD_CYCLES = 400;

  typedef struct {
    logic               req_type;
    logic signed [11:0] sx;
    logic signed [11:0] sy;
    logic               vp;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic [31:0]        flags;
    logic [31:0]        word;
    logic [31:0]        id;
    bit                 drain;
  } vtx_req_t;

  typedef struct packed {
    logic        hit;
    status_t     status;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] flags;
    logic [31:0] word;
    logic [31:0] id;
  } vtx_rsp_t;

  logic clk = 1'b0;
  logic rst_n;

  skvc_req_if req_ch ();
  skvc_rsp_if rsp_ch ();

  screen_keyed_vertex_cache #(.COORD_BITS(CB)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_rsp (rsp_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predicted cache contents and session state.
  entry_t      vcache_mem [ENTRIES];
  mode_t       vmode;
  logic [31:0] sess_base;
  logic [31:0] sess_last;

  vtx_req_t req_backlog_q[$];
  vtx_rsp_t awaited_rsp_q[$];
  vtx_req_t cur_req;

  int unsigned sent_cnt = 0;
  int unsigned recv_cnt = 0;
  int          err_cnt = 0;
  int          idle_cycles = 0;

  int gap_left = 0;
  int burst_left = 0;
  int hold_left = 0;
  bit held_once = 0;
  int win_left = 0;
  int ready_style = 0;

  logic signed [11:0] hot_x [16];
  logic signed [11:0] hot_y [16];
  logic [31:0]        id_run;

  task automatic report_mismatch(string msg);
    if (err_cnt < 40) $display("%0t mismatch: %s", $time, msg);
    err_cnt++;
  endtask

  function automatic bit in_session(logic [31:0] id);
    if (sess_last >= sess_base) return id >= sess_base;
    return (id >= sess_base) || (id <= sess_last);
  endfunction

  function automatic bit far_apart(logic [31:0] a, logic [31:0] b);
    longint d;
    d = longint'($signed(a)) - longint'($signed(b));
    if (d < 0) d = -d;
    return d > NEAR_LIMIT;
  endfunction

  function automatic bit locate_entry(input logic signed [11:0] cx, input logic signed [11:0] cy,
                                      output int unsigned slot);
    int xi;
    int yi;
    xi = cx;
    yi = cy;
    slot = 0;
    if (xi < -HALF || xi > HALF - 1 || yi < -HALF || yi > HALF - 1) return 1'b0;
    slot = ((yi + HALF) << CB) | (xi + HALF);
    return 1'b1;
  endfunction

  // Applies one request to the predicted cache and returns the result it should give.
  function automatic vtx_rsp_t apply_request(vtx_req_t r);
    vtx_rsp_t    o;
    int unsigned slot;
    entry_t      e;
    o = '0;
    o.status = STAT_NONE;
    if (r.req_type == REQ_STORE) begin
      if (!r.vp) begin
        vmode = CM_FAIL;
        o.status = STAT_FAIL;
        return o;
      end
      if (vmode != CM_WRITE) begin
        vmode = CM_WRITE;
        sess_base = r.id;
      end
      sess_last = r.id;
      if (!locate_entry(r.sx, r.sy, slot)) return o;
      e = vcache_mem[slot];
      if (in_session(e.id) && e.word == r.word &&
          (far_apart(e.x, r.px) || far_apart(e.y, r.py) || far_apart(e.z, r.pz))) begin
        vcache_mem[slot].mark = MARK_AMBIG;
        o.status = STAT_AMBIG;
        return o;
      end
      e.x = r.px;
      e.y = r.py;
      e.z = r.pz;
      e.flags = r.flags;
      e.word = r.word;
      e.id = r.id;
      e.mark = MARK_VALID;
      vcache_mem[slot] = e;
      o.status = STAT_WRITTEN;
      return o;
    end
    if (vmode == CM_FAIL) return o;
    vmode = CM_READ;
    if (!locate_entry(r.sx, r.sy, slot)) return o;
    e = vcache_mem[slot];
    if (in_session(e.id) && e.mark == MARK_VALID) begin
      o.hit = 1'b1;
      o.x = e.x;
      o.y = e.y;
      o.z = e.z;
      o.flags = e.flags;
      o.word = e.word;
      o.id = e.id;
    end
    return o;
  endfunction

  function automatic vtx_req_t store_req(logic signed [11:0] sx, logic signed [11:0] sy,
                                         logic signed [31:0] px, logic signed [31:0] py,
                                         logic signed [31:0] pz, logic [31:0] word,
                                         logic [31:0] id);
    vtx_req_t r;
    r.req_type = REQ_STORE;
    r.sx = sx;
    r.sy = sy;
    r.vp = 1'b1;
    r.px = px;
    r.py = py;
    r.pz = pz;
    r.flags = $urandom;
    r.word = word;
    r.id = id;
    r.drain = 1'b0;
    return r;
  endfunction

  // Lookups carry random payload so that every payload bit also moves on them.
  function automatic vtx_req_t lookup_req(logic signed [11:0] sx, logic signed [11:0] sy);
    vtx_req_t r;
    r = store_req(sx, sy, $urandom, $urandom, $urandom, $urandom, $urandom);
    r.req_type = REQ_LOOKUP;
    r.vp = 1'($urandom_range(0, 1));
    return r;
  endfunction

  function automatic logic signed [11:0] rand_coord();
    int t;
    t = $urandom_range(0, 2 * HALF - 1);
    return 12'(t - HALF);
  endfunction

  function automatic int near_delta();
    int d;
    d = ($urandom_range(0, 3) == 0) ? 6553 : $urandom_range(0, 6553);
    return $urandom_range(0, 1) ? -d : d;
  endfunction

  function automatic int far_delta();
    int d;
    d = ($urandom_range(0, 2) == 0) ? 6554 : $urandom_range(6554, 400000);
    return $urandom_range(0, 1) ? -d : d;
  endfunction

  task automatic push_req(vtx_req_t r);
    req_backlog_q.push_back(r);
  endtask

  task automatic build_directed();
    vtx_req_t r;
    r = store_req(-12'sd128, -12'sd128, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF);
    r.flags = 32'hFFFF_FFFF;
    push_req(r);
    // A cleared entry has word zero and id zero, which is in the wrapped session.
    r = store_req(12'sd127, 12'sd127, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0);
    r.flags = 0;
    push_req(r);
    push_req(store_req(12'sd127, 12'sd127, 0, 0, 0, 0, 1));
    push_req(lookup_req(-12'sd128, -12'sd128));
    push_req(lookup_req(12'sd127, 12'sd127));
    push_req(store_req(12'sd5, 12'sd5, 0, 0, 0, 32'h1234, 10));
    push_req(store_req(12'sd5, 12'sd5, 6553, 0, 0, 32'h1234, 11));
    push_req(store_req(12'sd5, 12'sd5, 13107, 0, 0, 32'h1234, 12));
    push_req(store_req(12'sd6, 12'sd5, 0, 0, 0, 7, 13));
    push_req(store_req(12'sd6, 12'sd5, 32'h7FFF_FFFF, 0, 0, 8, 14));
    push_req(lookup_req(12'sd5, 12'sd5));
    push_req(lookup_req(12'sd6, 12'sd5));
    push_req(lookup_req(12'sd127, 12'sd127));
    push_req(lookup_req(-12'sd2048, 12'sd2047));
    push_req(lookup_req(12'sd128, 12'sd0));
    push_req(store_req(12'sd2047, -12'sd2048, 1, 2, 3, 4, 20));
    r = store_req(12'sd6, 12'sd5, 0, 0, 0, 9, 21);
    r.vp = 1'b0;
    push_req(r);
    push_req(lookup_req(12'sd6, 12'sd5));
    push_req(store_req(12'sd6, 12'sd5, 0, 0, 0, 9, 30));
    push_req(lookup_req(12'sd6, 12'sd5));
    push_req(store_req(12'sd0, 12'sd0, 0, 0, 0, 3, 31));
    push_req(store_req(12'sd0, 12'sd0, 0, 32'h0001_0000, 0, 3, 32));
    push_req(store_req(12'sd0, 12'sd0, 0, 0, -6554, 3, 33));
    push_req(lookup_req(12'sd0, 12'sd0));
    push_req(lookup_req(-12'sd1, -12'sd128));
  endtask

  // One write session over up to six entries, then a read phase mostly over the same entries.
  task automatic gen_session(bit drain_first);
    int                 n_st;
    int                 n_lk;
    int                 i;
    int                 k;
    int                 ax;
    int                 sel;
    logic signed [11:0] gx [6];
    logic signed [11:0] gy [6];
    logic [31:0]        gw [6];
    logic signed [31:0] lp [6][3];
    logic signed [31:0] p [3];
    logic [31:0]        id;
    vtx_req_t           r;
    bit                 first;
    first = drain_first;
    case ($urandom_range(0, 5))
      0: id = 32'hFFFF_FFF8 + $urandom_range(0, 7);
      1: id = $urandom;
      default: id = id_run;
    endcase
    for (k = 0; k < 6; k++) begin
      if ($urandom_range(0, 3) != 0) begin
        i = $urandom_range(0, 15);
        gx[k] = hot_x[i];
        gy[k] = hot_y[i];
      end else begin
        gx[k] = rand_coord();
        gy[k] = rand_coord();
      end
      gw[k] = $urandom_range(0, 3);
      for (ax = 0; ax < 3; ax++) lp[k][ax] = $urandom;
    end
    n_st = $urandom_range(3, 16);
    for (i = 0; i < n_st; i++) begin
      k = $urandom_range(0, 5);
      for (ax = 0; ax < 3; ax++) p[ax] = lp[k][ax];
      sel = $urandom_range(0, 3);
      if (sel == 0 || sel == 1) begin
        for (ax = 0; ax < 3; ax++) p[ax] = p[ax] + near_delta();
      end
      if (sel == 1) begin
        ax = $urandom_range(0, 2);
        p[ax] = p[ax] + far_delta();
      end
      if (sel == 3) begin
        for (ax = 0; ax < 3; ax++) p[ax] = $urandom;
      end
      r = store_req(gx[k], gy[k], p[0], p[1], p[2],
                    ($urandom_range(0, 3) != 0) ? gw[k] : $urandom, id);
      if ($urandom_range(0, 29) == 0) r.vp = 1'b0;
      if ($urandom_range(0, 24) == 0) r.sx = 12'($urandom_range(0, 4095));
      if ($urandom_range(0, 24) == 0) r.sy = 12'($urandom_range(0, 4095));
      r.drain = first;
      first = 1'b0;
      push_req(r);
      for (ax = 0; ax < 3; ax++) lp[k][ax] = p[ax];
      id = id + (($urandom_range(0, 15) == 0) ? $urandom : 1);
    end
    id_run = id;
    n_lk = $urandom_range(3, 12);
    for (i = 0; i < n_lk; i++) begin
      sel = $urandom_range(0, 9);
      if (sel < 8) begin
        k = $urandom_range(0, 5);
        r = lookup_req(gx[k], gy[k]);
      end else if (sel == 8) begin
        k = $urandom_range(0, 15);
        r = lookup_req(hot_x[k], hot_y[k]);
      end else begin
        r = lookup_req(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
      end
      push_req(r);
    end
    if ($urandom_range(0, 9) == 0) begin
      n_st = $urandom_range(1, 3);
      for (i = 0; i < n_st; i++) begin
        r = lookup_req(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
        r.req_type = 1'($urandom_range(0, 1));
        push_req(r);
      end
    end
  endtask

  // Request driver: bursts of random length with random gaps.
  always @(posedge clk) begin
    int unsigned n_sent;
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
    end else begin
      n_sent = sent_cnt;
      if (req_ch.valid && req_ch.ready) begin
        awaited_rsp_q.push_back(apply_request(cur_req));
        n_sent++;
        sent_cnt <= n_sent;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          req_ch.valid <= 1'b0;
        end else if (req_backlog_q.size() > 0 &&
                     (!req_backlog_q[0].drain || n_sent == recv_cnt)) begin
          cur_req = req_backlog_q.pop_front();
          req_ch.req_type       <= cur_req.req_type;
          req_ch.sx             <= cur_req.sx;
          req_ch.sy             <= cur_req.sy;
          req_ch.vertex_present <= cur_req.vp;
          req_ch.pos_x          <= cur_req.px;
          req_ch.pos_y          <= cur_req.py;
          req_ch.pos_z          <= cur_req.pz;
          req_ch.vert_flags     <= cur_req.flags;
          req_ch.vert_word      <= cur_req.word;
          req_ch.vert_id        <= cur_req.id;
          req_ch.valid          <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %h want %h", recv_cnt, name, got, want));
  endtask

  // Result monitor and the receiver's stall pattern.
  always @(posedge clk) begin
    vtx_rsp_t want;
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      recv_cnt <= recv_cnt + 1;
      if (awaited_rsp_q.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with no request waiting", recv_cnt));
      end else begin
        want = awaited_rsp_q.pop_front();
        check_field("hit", 32'(rsp_ch.hit), 32'(want.hit));
        check_field("store_status", 32'(rsp_ch.store_status), 32'(want.status));
        check_field("out_x", rsp_ch.out_x, want.x);
        check_field("out_y", rsp_ch.out_y, want.y);
        check_field("out_z", rsp_ch.out_z, want.z);
        check_field("out_flags", rsp_ch.out_flags, want.flags);
        check_field("out_word", rsp_ch.out_word, want.word);
        check_field("out_id", rsp_ch.out_id, want.id);
      end
    end
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      // One long hold-off lets the block back up into its request side.
      if (!held_once && sent_cnt >= 300) begin
        held_once = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        if (win_left == 0) begin
          win_left = $urandom_range(8, 64);
          ready_style = $urandom_range(0, 3);
        end
        win_left--;
        case (ready_style)
          2: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
          3: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
          default: rsp_ch.ready <= 1'b1;
        endcase
      end
    end
  end

  // Watchdog on cycles without any handshake; covers the clearing pass after reset.
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("[screen_keyed_vertex_cache] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int i;
    rst_n = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_STORE;
    req_ch.sx = '0;
    req_ch.sy = '0;
    req_ch.vertex_present = 1'b0;
    req_ch.pos_x = '0;
    req_ch.pos_y = '0;
    req_ch.pos_z = '0;
    req_ch.vert_flags = '0;
    req_ch.vert_word = '0;
    req_ch.vert_id = '0;
    rsp_ch.ready = 1'b0;

    vmode = CM_INIT;
    sess_base = '0;
    sess_last = '0;
    foreach (vcache_mem[j]) vcache_mem[j] = '0;

    hot_x[0] = 12'(-HALF);
    hot_y[0] = 12'(-HALF);
    hot_x[1] = 12'(HALF - 1);
    hot_y[1] = 12'(HALF - 1);
    for (i = 2; i < 16; i++) begin
      hot_x[i] = rand_coord();
      hot_y[i] = rand_coord();
    end

    build_directed();
    id_run = 100;
    gen_session(1'b1);
    while (req_backlog_q.size() < ITEM_TARGET)
      gen_session($urandom_range(0, 7) == 0);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (req_backlog_q.size() != 0 || req_ch.valid || sent_cnt != recv_cnt);
    repeat (20) @(posedge clk);
    if (awaited_rsp_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", awaited_rsp_q.size()));

    if (err_cnt == 0) begin
      $display("[screen_keyed_vertex_cache] OK");
    end else begin
      $display("[screen_keyed_vertex_cache] ERROR");
    end
    $finish;
  end

endmodule

### sim.f
rtl/skvc_pkg.sv
rtl/skvc_if.sv
rtl/skvc_ram.sv
rtl/screen_keyed_vertex_cache.sv
rtl/skvc_checker.sv
tb/sv/tb_screen_keyed_vertex_cache.sv
